/* rtl/fp8c_pkg.sv */
// Shared types and constants for the single-precision to 8-bit float cast.
// No dependencies; used by fp8c_cfg, fp8c_core and the top level.

package fp8c_pkg;

  // Configuration register indexes on the write port.
  typedef enum logic [1:0] {
    CFG_MANTISSA_BITS = 2'd0,
    CFG_FNUZ_MODE     = 2'd1,
    CFG_CLIP_ENABLE   = 2'd2,
    CFG_STOCHASTIC    = 2'd3
  } cfg_idx_e;

  // Current configuration, handed from the register file to the datapath.
  typedef struct packed {
    logic [1:0] mantissa_bits;
    logic       fnuz_mode;
    logic       clip_enable;
    logic       stochastic_enable;
  } cfg_t;

  localparam logic [1:0] MANT_BITS_RESET = 2'd3;
  localparam logic       FNUZ_RESET      = 1'b1;
  localparam logic       CLIP_RESET      = 1'b1;
  localparam logic       STOCH_RESET     = 1'b0;

  // Mantissa width code that selects E5M2; every other code selects E4M3.
  localparam logic [1:0] MANT_BITS_E5M2 = 2'd2;

  localparam logic [7:0] F32_EXP_SPECIAL = 8'hFF;
  localparam logic [8:0] F32_EXP_BIAS    = 9'd127;

  // Fixed 8-bit codes, without the sign bit unless noted.
  localparam logic [7:0] FNUZ_NAN_CODE = 8'h80;
  localparam logic [6:0] MAX_E4M3_IEEE = 7'h7E;
  localparam logic [6:0] MAX_E5M2_IEEE = 7'h7B;
  localparam logic [6:0] INF_E5M2      = 7'h7C;
  localparam logic [6:0] ALL_ONES_CODE = 7'h7F;

endpackage

/* rtl/fp8c_cfg.sv */
// Configuration register file for the 8-bit float cast.
// Depends on fp8c_pkg for the register index codes and the cfg_t struct.

module fp8c_cfg import fp8c_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [1:0] cfg_data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // The register file takes a write in every cycle.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MANTISSA_BITS: cfg_d.mantissa_bits     = cfg_data_i;
        CFG_FNUZ_MODE:     cfg_d.fnuz_mode         = cfg_data_i[0];
        CFG_CLIP_ENABLE:   cfg_d.clip_enable       = cfg_data_i[0];
        CFG_STOCHASTIC:    cfg_d.stochastic_enable = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mantissa_bits     <= MANT_BITS_RESET;
      cfg_q.fnuz_mode         <= FNUZ_RESET;
      cfg_q.clip_enable       <= CLIP_RESET;
      cfg_q.stochastic_enable <= STOCH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/fp8c_core.sv */
// Combinational conversion datapath: binary32 pattern to E4M3/E5M2 code.
// Depends on fp8c_pkg for cfg_t and the fixed output codes.

module fp8c_core import fp8c_pkg::*; (
  input  cfg_t        cfg_i,
  input  logic [31:0] value_bits_i,
  input  logic [20:0] random_bits_i,
  output logic [7:0]  fp8_bits_o
);

  logic        is_e5;
  logic        sgn;
  logic [7:0]  expo;
  logic [22:0] frac;
  logic [4:0]  bias;
  logic [7:0]  den_lim;
  logic        subnorm;
  logic [7:0]  diff_raw;
  logic [4:0]  shamt;
  logic [23:0] man;
  logic [23:0] man_sh;
  logic        sticky;
  logic [20:0] low_mask;
  logic [20:0] low;
  logic [20:0] half;
  logic        odd;
  logic        midpoint;
  logic [20:0] addend;
  logic [24:0] sum;
  logic [24:0] sum_n;
  logic [8:0]  exp_base;
  logic [8:0]  f8e;
  logic [2:0]  mf;
  logic [8:0]  max_exp;
  logic        over;
  logic [7:0]  max_code;
  logic [7:0]  ovf_code;

  assign is_e5 = (cfg_i.mantissa_bits == MANT_BITS_E5M2);
  assign sgn   = value_bits_i[31];
  assign expo  = value_bits_i[30:23];
  assign frac  = value_bits_i[22:0];

  // Exponent bias of the target format; FNUZ adds one.
  assign bias = (is_e5 ? 5'd15 : 5'd7) + {4'd0, cfg_i.fnuz_mode};

  // Inputs below the smallest normal exponent of the target become
  // subnormals: the mantissa is shifted right by the exponent deficit.
  assign den_lim  = 8'd128 - {3'd0, bias};
  assign subnorm  = (expo < den_lim);
  assign diff_raw = den_lim - expo;
  assign shamt    = !subnorm ? 5'd0 : ((diff_raw >= 8'd24) ? 5'd24 : diff_raw[4:0]);

  assign man    = {(expo != 8'd0), frac};
  assign man_sh = man >> shamt;
  assign sticky = |(man & ~({24{1'b1}} << shamt));

  // Bits below the kept mantissa: 20 for E4M3, 21 for E5M2.
  assign low_mask = is_e5 ? 21'h1FFFFF : 21'h0FFFFF;
  assign low      = man_sh[20:0] & low_mask;
  assign half     = is_e5 ? 21'h100000 : 21'h080000;
  assign odd      = is_e5 ? man_sh[21] : man_sh[20];
  assign midpoint = !sticky && (low == half);

  // Round to nearest even adds the dropped bits to themselves, which carries
  // exactly when they reach one half; at a tie an even value adds one less.
  always_comb begin
    if (cfg_i.stochastic_enable) begin
      addend = random_bits_i & low_mask;
    end else if (midpoint) begin
      addend = odd ? low : (low - 21'd1);
    end else begin
      addend = low;
    end
  end

  assign sum      = {1'b0, man_sh} + {4'd0, addend};
  assign sum_n    = sum[24] ? (sum >> 1) : sum;
  assign exp_base = subnorm ? 9'd0 : ({1'b0, expo} + {4'd0, bias} - F32_EXP_BIAS);

  // A subnormal that rounds up into the hidden bit becomes the smallest
  // normal; a normal whose mantissa overflows moves up one binade.
  assign f8e = exp_base + {8'd0, sum[24] | ((exp_base == 9'd0) && sum[23])};
  assign mf  = is_e5 ? {1'b0, sum_n[22:21]} : sum_n[22:20];

  always_comb begin
    if (!is_e5) begin
      max_exp = 9'd15;
    end else if (cfg_i.fnuz_mode) begin
      max_exp = 9'd31;
    end else begin
      max_exp = 9'd30;
    end
  end

  // In IEEE-like E4M3 the all-ones code is NaN, so it counts as overflow.
  assign over = (f8e > max_exp) ||
                (!cfg_i.fnuz_mode && !is_e5 && (f8e == 9'd15) && (mf == 3'd7));

  always_comb begin
    if (cfg_i.fnuz_mode) begin
      max_code = {sgn, ALL_ONES_CODE};
      ovf_code = FNUZ_NAN_CODE;
    end else if (is_e5) begin
      max_code = {sgn, MAX_E5M2_IEEE};
      ovf_code = {sgn, INF_E5M2};
    end else begin
      max_code = {sgn, MAX_E4M3_IEEE};
      ovf_code = {sgn, ALL_ONES_CODE};
    end
  end

  always_comb begin
    if (expo == F32_EXP_SPECIAL) begin
      if (cfg_i.fnuz_mode) begin
        fp8_bits_o = FNUZ_NAN_CODE;
      end else if (frac == 23'd0) begin
        fp8_bits_o = {sgn, (is_e5 ? MAX_E5M2_IEEE : MAX_E4M3_IEEE)};
      end else begin
        fp8_bits_o = {sgn, ALL_ONES_CODE};
      end
    end else if (over) begin
      fp8_bits_o = cfg_i.clip_enable ? max_code : ovf_code;
    end else if ((f8e == 9'd0) && (mf == 3'd0)) begin
      fp8_bits_o = cfg_i.fnuz_mode ? 8'h00 : {sgn, 7'd0};
    end else if (is_e5) begin
      fp8_bits_o = {sgn, f8e[4:0], mf[1:0]};
    end else begin
      fp8_bits_o = {sgn, f8e[3:0], mf};
    end
  end

endmodule

/* rtl/fp32_to_fp8_configurable_cast.sv */
// Top level of the binary32 to 8-bit float cast: handshake and pipeline.
// Depends on fp8c_pkg, fp8c_cfg and fp8c_core.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         in_valid_i / in_stall_o   value_bits_i, random_bits_i
//   output   out        out_valid_o / out_stall_i fp8_bits_o
//   config   in         cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// An accepted item is captured in the input register, converted by the
// combinational datapath and written into the result register, which offers
// it on the output. One item is taken in every cycle while in_stall_o is low.
// Reset empties both registers and loads the default configuration.
// in_stall_o rises only when both registers hold items and the output is
// stalled; a waiting result never blocks the input register from filling.

module fp32_to_fp8_configurable_cast import fp8c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] value_bits_i,
  input  logic [20:0] random_bits_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  fp8_bits_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i
);

  cfg_t        cfg;
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_value_q;
  logic [20:0] s1_random_q;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_bits_q;
  logic [7:0]  conv_bits;
  logic        out_load;
  logic        in_xfer;

  fp8c_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fp8c_core u_core (
    .cfg_i         (cfg),
    .value_bits_i  (s1_value_q),
    .random_bits_i (s1_random_q),
    .fp8_bits_o    (conv_bits)
  );

  // The result register loads when it is empty or its item is taken; the
  // input register then drains into it and may refill in the same cycle.
  assign out_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (!in_stall_o) begin
      s1_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = s1_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers carry no reset; their valid bits guard them.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_value_q  <= value_bits_i;
      s1_random_q <= random_bits_i;
    end
    if (out_load && s1_valid_q) begin
      out_bits_q <= conv_bits;
    end
  end

  assign out_valid_o = out_valid_q;
  assign fp8_bits_o  = out_bits_q;

  // The input side stalls only while an item waits in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // An input transfer always lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted item lost before the input register");

  // A blocked item in the input register keeps its operands.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_o && out_stall_i) |=>
      ($stable(s1_value_q) && $stable(s1_random_q) && s1_valid_q))
    else $error("blocked item changed in the input register");

  // A result taken with nothing behind it leaves the output empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !s1_valid_q) |=> !out_valid_o)
    else $error("result repeated after its transfer");

endmodule

/* dv/fp8c_checker.sv */
// Scoreboard for the binary32 to 8-bit float cast: watches all three channels,
// predicts each 8-bit code and compares it with the block's output.
// Depends on fp8c_pkg for the configuration types, indexes and fixed codes.

module fp8c_checker import fp8c_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [31:0] value_bits_i,
  input  logic [20:0] random_bits_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  fp8_bits_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [1:0]  cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] value;
    logic [20:0] rng;
    logic [7:0]  fp8;
  } cast_expect_t;

  cast_expect_t cast_expect_q[$];
  cfg_t         cfg_q = '{MANT_BITS_RESET, FNUZ_RESET, CLIP_RESET, STOCH_RESET};
  int           mismatch_count = 0;
  int           pending_count = 0;

  assign fail_count_o = mismatch_count;
  assign pending_o    = pending_count;

  task automatic report_mismatch(input string what);
    $display("[%0t] cast checker: %s", $time, what);
    mismatch_count++;
  endtask

  // Expected 8-bit code for one binary32 pattern under the current settings.
  function automatic logic [7:0] predict_fp8(logic [31:0] x, logic [20:0] rng);
    int          wm, we, bias, den_exp, act, diff, f8e, max_exp;
    bit          fnuz, midpoint, odd, over;
    int unsigned s, drop;
    logic [31:0] sbit, man, all_ones, inf_code, max_code, round_mask, addend, mfield;
    logic [7:0]  expo;
    wm       = (cfg_q.mantissa_bits == MANT_BITS_E5M2) ? 2 : 3;
    we       = 7 - wm;
    fnuz     = cfg_q.fnuz_mode;
    sbit     = {24'd0, x[31], 7'd0};
    expo     = x[30:23];
    man      = {9'd0, x[22:0]};
    all_ones = sbit | 32'h7F;
    inf_code = sbit | (((32'd1 << we) - 32'd1) << wm);
    max_code = all_ones;
    if (!fnuz) max_code = (wm == 2) ? all_ones - 32'd4 : all_ones - 32'd1;

    if (expo == F32_EXP_SPECIAL) begin
      if (fnuz) return FNUZ_NAN_CODE;
      if (x[22:0] == 23'd0) return {x[31], (wm == 2) ? MAX_E5M2_IEEE : MAX_E4M3_IEEE};
      return 8'(all_ones);
    end

    bias    = (1 << (we - 1)) - 1 + (fnuz ? 1 : 0);
    den_exp = 1 - bias;
    if (expo == 8'd0) begin
      act  = -126;
      diff = den_exp - act;
    end else begin
      act  = int'(expo) - int'(F32_EXP_BIAS);
      diff = (act <= den_exp) ? den_exp - act : 0;
      man  = man | 32'h0080_0000;
    end

    // A tie is judged on the mantissa before the denormalizing shift.
    s        = 23 - wm + diff;
    midpoint = (s < 32) && ((man & ((32'd1 << s) - 32'd1)) == (32'd1 << (s - 1)));
    man      = (diff >= 32) ? 32'd0 : (man >> diff);
    f8e      = act + diff + bias - (man[23] ? 0 : 1);

    drop       = 23 - wm;
    round_mask = (32'd1 << drop) - 32'd1;
    odd        = man[drop];
    if (cfg_q.stochastic_enable) addend = 32'(rng);
    else if (midpoint)           addend = odd ? man : man - 32'd1;
    else                         addend = man;
    man = man + (addend & round_mask);

    if (f8e == 0 && man[23]) begin
      f8e = 1;
    end else if (man[24]) begin
      man = man >> 1;
      f8e++;
    end
    man    = man >> drop;
    mfield = man & ((32'd1 << wm) - 32'd1);

    max_exp = (1 << we) - ((fnuz || wm == 3) ? 1 : 2);
    // In IEEE E4M3 the all-ones code is NaN, so landing on it is an overflow.
    over = (f8e > max_exp) || (!fnuz && wm == 3 && f8e == 15 && mfield == 32'd7);
    if (over) begin
      if (cfg_q.clip_enable) return 8'(max_code);
      if (fnuz) return FNUZ_NAN_CODE;
      return (wm == 2) ? 8'(inf_code) : 8'(all_ones);
    end
    if (f8e == 0 && mfield == 32'd0) return fnuz ? 8'd0 : 8'(sbit);
    return 8'(sbit | (32'(f8e) << wm) | mfield);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cast_expect_t head;
    if (!rst_ni) begin
      cast_expect_q.delete();
      pending_count = 0;
      cfg_q = '{MANT_BITS_RESET, FNUZ_RESET, CLIP_RESET, STOCH_RESET};
    end else begin
      // A result passes through the input and result registers before it leaves,
      // so the output side is handled before this edge's input transfer is queued.
      if (out_valid_i && !out_stall_i) begin
        if (cast_expect_q.size() == 0) begin
          report_mismatch($sformatf("result %h with no item outstanding", fp8_bits_i));
        end else begin
          head = cast_expect_q.pop_front();
          if (fp8_bits_i !== head.fp8)
            report_mismatch($sformatf("value %h rng %h: fp8_bits %h, predicted %h (cfg %b)",
                                      head.value, head.rng, fp8_bits_i, head.fp8, cfg_q));
        end
      end
      if (in_valid_i && !in_stall_i)
        cast_expect_q.push_back('{value_bits_i, random_bits_i,
                                  predict_fp8(value_bits_i, random_bits_i)});
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_MANTISSA_BITS: cfg_q.mantissa_bits     = cfg_data_i;
          CFG_FNUZ_MODE:     cfg_q.fnuz_mode         = cfg_data_i[0];
          CFG_CLIP_ENABLE:   cfg_q.clip_enable       = cfg_data_i[0];
          CFG_STOCHASTIC:    cfg_q.stochastic_enable = cfg_data_i[0];
          default: ;
        endcase
      end
      pending_count = cast_expect_q.size();
    end
  end

endmodule

/* dv/tb.sv */
// Top of the cast testbench: clock, reset, configuration phases, stimulus and
// random back-pressure. Depends on fp8c_pkg, the cast block and fp8c_checker.

module tb import fp8c_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Every input of the block starts at a known value.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic [31:0] value_bits_i = 32'd0;
  logic [20:0] random_bits_i = 21'd0;
  logic        out_stall_i = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic [1:0]  cfg_index_i = 2'd0;
  logic [1:0]  cfg_data_i = 2'd0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [7:0]  fp8_bits_o;
  logic        cfg_ready_o;
  int          fail_count;
  int          pending;

  // Stretches of back-to-back traffic on the input side.
  int          send_burst = 0;

  always #10 clk_i = ~clk_i;

  fp32_to_fp8_configurable_cast dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_bits_i (value_bits_i),
    .random_bits_i(random_bits_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fp8_bits_o   (fp8_bits_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  fp8c_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .value_bits_i (value_bits_i),
    .random_bits_i(random_bits_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .fp8_bits_i   (fp8_bits_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Directed values: signed zeros, infinities, NaNs of both signs, the largest
  // and smallest binary32 magnitudes, the top of each 8-bit range (including
  // the value that rounds onto the E4M3 NaN code), ties to even, the smallest
  // subnormal outputs and half of them, and inputs so tiny that the
  // denormalizing shift clears everything.
  logic [31:0] directed_vals [] = '{
    32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
    32'h7FC0_0000, 32'hFFC0_0001, 32'h7F7F_FFFF, 32'h0000_0001,
    32'h807F_FFFF, 32'h3F80_0000, 32'hBF80_0000, 32'h43E0_0000,
    32'h43E8_0000, 32'h43F0_0000, 32'h4760_0000, 32'h4770_0000,
    32'h3F88_0000, 32'h3F98_0000, 32'h3B00_0000, 32'h3A80_0000,
    32'hBA00_0000, 32'h2F00_0000, 32'hFFFF_FFFF
  };

  // Random binary32 patterns, weighted toward exponents near the 8-bit range
  // and toward mantissas that sit on a tie or carry all the way up.
  function automatic logic [31:0] draw_value();
    int          sel, k;
    logic        sgn;
    logic [7:0]  e;
    logic [22:0] m;
    sel = $urandom_range(0, 99);
    sgn = 1'($urandom_range(0, 1));
    e   = 8'($urandom_range(102, 144));
    m   = 23'($urandom);
    if (sel < 5) begin
      e = F32_EXP_SPECIAL;
      if ($urandom_range(0, 1) == 0) m = 23'd0;
    end else if (sel < 12) begin
      e = 8'd0;
      if ($urandom_range(0, 3) == 0) m = 23'd1 << $urandom_range(0, 22);
    end else if (sel < 70) begin
      // Plain values in and around the representable range.
    end else if (sel < 82) begin
      k = $urandom_range(17, 23);
      m = ((m >> k) << k) | (23'd1 << (k - 1));
    end else if (sel < 92) begin
      k = $urandom_range(17, 23);
      m = m | ((23'd1 << k) - 23'd1);
    end else if (sel < 95) begin
      m = 23'd0;
    end else begin
      return $urandom;
    end
    return {sgn, e, m};
  endfunction

  // Offers one item after a random gap and returns at the edge of its transfer.
  // With no gap, valid simply stays high while the payload moves on.
  task automatic send_item(input logic [31:0] value, input logic [20:0] rng);
    int gap;
    if (send_burst > 0) begin
      gap = 0;
      send_burst--;
    end else begin
      gap = $urandom_range(0, 15);
      if ($urandom_range(0, 7) == 0) send_burst = $urandom_range(10, 40);
    end
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    value_bits_i  <= value;
    random_bits_i <= rng;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // One register write; valid is left high so that writes can run back to back.
  task automatic write_cfg(input cfg_idx_e idx, input logic [1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes all four registers. The unused upper data bit of the one-bit
  // registers is randomized, since only bit zero should matter.
  task automatic set_config(input logic [1:0] mbits, input logic fnuz,
                            input logic clip, input logic stoch);
    write_cfg(CFG_MANTISSA_BITS, mbits);
    write_cfg(CFG_FNUZ_MODE,     {1'($urandom), fnuz});
    write_cfg(CFG_CLIP_ENABLE,   {1'($urandom), clip});
    write_cfg(CFG_STOCHASTIC,    {1'($urandom), stoch});
    cfg_valid_i <= 1'b0;
  endtask

  // Stops offering, waits for every outstanding result, then keeps idling so
  // the two-stage pipeline is certainly empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Receiver: stalls for a random number of cycles before each transfer out,
  // with bursts of no stall at all. Once, mid-run, it holds off for a long
  // stretch while the sender keeps offering, so the block fills and pushes
  // back on its input.
  initial begin
    int n, taken, burst;
    taken = 0;
    burst = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (taken == 750) begin
        n = 400;
      end else if (burst > 0) begin
        n = 0;
        burst--;
      end else begin
        n = $urandom_range(0, 15);
        if ($urandom_range(0, 7) == 0) burst = $urandom_range(10, 40);
      end
      repeat (n) begin
        out_stall_i <= 1'b1;
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
      taken++;
    end
  end

  // Main sequence: reset, directed values under the reset settings, then
  // random phases that walk every combination of format, FNUZ, clipping and
  // rounding mode, followed by the unused mantissa codes and random settings.
  initial begin
    logic [1:0] mbits;
    logic [3:0] combo;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_vals[i]) send_item(directed_vals[i], 21'($urandom));
    drain();

    for (int phase = 0; phase < 20; phase++) begin
      combo = 4'($urandom);
      if (phase < 16) combo = 4'(phase);
      mbits = combo[3] ? MANT_BITS_E5M2 : 2'd3;
      if (phase == 16) mbits = 2'd0;
      if (phase == 17) mbits = 2'd1;
      if (phase >= 18) mbits = 2'($urandom);
      set_config(mbits, combo[2], combo[1], combo[0]);
      repeat (100) send_item(draw_value(), 21'($urandom));
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #(10_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* fp32_to_fp8_configurable_cast.f */
rtl/fp8c_pkg.sv
rtl/fp8c_cfg.sv
rtl/fp8c_core.sv
rtl/fp32_to_fp8_configurable_cast.sv
dv/fp8c_checker.sv
dv/tb.sv
